// ===== rtl/upd_pkg.sv =====
// Shared types, character constants and hex helpers for the URL percent decoder.
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  // Escape progress of the front end.
  typedef enum logic [2:0] {
    HELD_NONE    = 3'b001,
    HELD_PERCENT = 3'b010,
    HELD_DIGIT   = 3'b100
  } held_t;

  // One queue entry: up to three candidate bytes in order, plus an end-of-string mark.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            close;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end
    hex_val = v[3:0];
  endfunction

endpackage

// ===== rtl/upd_front.sv =====
// Front end: tracks escape state and turns each input item into a list of candidate bytes.
module upd_front import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       cmd,
  input  logic [7:0] src_byte,
  output logic       push,
  output entry_t     entry
);

  held_t      held, held_next;
  logic [7:0] held_digit, held_digit_next;

  logic       plain_hold;
  logic [7:0] plain_out;

  assign plain_hold = (src_byte == CH_PERCENT);
  assign plain_out  = (src_byte == CH_PLUS) ? CH_SPACE : src_byte;

  always_comb begin
    logic [1:0] n;
    n               = 2'd0;
    entry           = '0;
    held_next       = held;
    held_digit_next = held_digit;
    if (cmd == CMD_END) begin
      if (held != HELD_NONE) begin
        entry.data[n] = CH_PERCENT;
        n             = n + 2'd1;
      end
      if (held == HELD_DIGIT) begin
        entry.data[n] = held_digit;
        n             = n + 2'd1;
      end
      entry.close     = 1'b1;
      held_next       = HELD_NONE;
      held_digit_next = 8'd0;
    end else begin
      case (held)
        HELD_PERCENT: begin
          if (is_hex(src_byte)) begin
            held_next       = HELD_DIGIT;
            held_digit_next = src_byte;
          end else begin
            entry.data[n]   = CH_PERCENT;
            n               = n + 2'd1;
            held_next       = HELD_NONE;
            held_digit_next = 8'd0;
            if (plain_hold) begin
              held_next = HELD_PERCENT;
            end else begin
              entry.data[n] = plain_out;
              n             = n + 2'd1;
            end
          end
        end
        HELD_DIGIT: begin
          held_next       = HELD_NONE;
          held_digit_next = 8'd0;
          if (is_hex(src_byte)) begin
            entry.data[n] = {hex_val(held_digit), hex_val(src_byte)};
            n             = n + 2'd1;
          end else begin
            entry.data[n] = CH_PERCENT;
            n             = n + 2'd1;
            entry.data[n] = held_digit;
            n             = n + 2'd1;
            if (plain_hold) begin
              held_next = HELD_PERCENT;
            end else begin
              entry.data[n] = plain_out;
              n             = n + 2'd1;
            end
          end
        end
        default: begin
          held_next       = HELD_NONE;
          held_digit_next = 8'd0;
          if (plain_hold) begin
            held_next = HELD_PERCENT;
          end else begin
            entry.data[n] = plain_out;
            n             = n + 2'd1;
          end
        end
      endcase
    end
    entry.cnt = n;
  end

  // Items that only extend an escape produce nothing for the back end.
  assign push = accept && ((entry.cnt != 2'd0) || entry.close);

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= HELD_NONE;
      held_digit <= 8'd0;
    end else if (accept) begin
      held       <= held_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

// ===== rtl/upd_queue.sv =====
// Small register queue that decouples the front end from the back end.
module upd_queue import upd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   nonempty,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== rtl/upd_back.sv =====
// Back end: capacity check, end-of-string result and the output register.
module upd_back import upd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        q_valid,
  input  entry_t      q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic        status
);

  logic [15:0] capacity;
  logic [15:0] written_count, written_count_next;
  logic        overflowed, overflowed_next;
  logic [1:0]  idx, idx_next;
  logic        out_valid_next;
  logic        load_byte, load_last;

  logic [2:0]  total;
  logic        step;
  logic        is_byte_slot;
  logic        fits;
  logic        slot_done;

  assign total        = {1'b0, q_head.cnt} + {2'b00, q_head.close};
  assign step         = q_valid && (!out_valid || out_ready);
  assign is_byte_slot = (idx < q_head.cnt);
  assign fits         = ({1'b0, written_count} + 17'd1) < {1'b0, capacity};
  assign slot_done    = ({1'b0, idx} + 3'd1) == total;
  assign q_pop        = step && slot_done;

  always_comb begin
    written_count_next = written_count;
    overflowed_next    = overflowed;
    idx_next           = idx;
    load_byte          = 1'b0;
    load_last          = 1'b0;
    out_valid_next     = out_valid && !out_ready;
    if (step) begin
      idx_next = slot_done ? 2'd0 : idx + 2'd1;
      if (is_byte_slot) begin
        if (!overflowed && fits) begin
          load_byte          = 1'b1;
          written_count_next = written_count + 16'd1;
        end else begin
          overflowed_next = 1'b1;
        end
      end else begin
        load_last          = 1'b1;
        written_count_next = 16'd0;
        overflowed_next    = 1'b0;
      end
      if (load_byte || load_last) begin
        out_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAPACITY_RESET;
      written_count <= 16'd0;
      overflowed    <= 1'b0;
      idx           <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      written_count <= written_count_next;
      overflowed    <= overflowed_next;
      idx           <= idx_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      out_byte   <= q_head.data[idx];
      byte_valid <= 1'b1;
      last       <= 1'b0;
      status     <= STATUS_OK;
    end else if (load_last) begin
      out_byte   <= 8'd0;
      byte_valid <= 1'b0;
      last       <= 1'b1;
      status     <= overflowed ? STATUS_OVERFLOW : STATUS_OK;
    end
  end

  a_byte_xor_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid != last)) else $error("result is neither byte nor end");
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last) else $error("overflow status on a byte result");
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> ({1'b0, idx} < total)) else $error("slot index past entry");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && !is_byte_slot |=> written_count == 16'd0 && !overflowed)
    else $error("string state not cleared after end");

endmodule

// ===== rtl/url_percent_decoder_unit.sv =====
// Top level of the URL percent decoder: front end, queue and back end.
//
// Input channel (in_valid/in_ready): one item per handshake, cmd = 0 carries an
// encoded byte in src_byte, cmd = 1 ends the string. Output channel
// (out_valid/out_ready): one result item per handshake with out_byte,
// byte_valid, last and status. The string's end item gives a final result with last
// set and status telling whether the decoded text overflowed. The user must write the
// capacity register via cfg_we/cfg_data only while idle; the block does not check it.
//
// An accepted item is written into the queue, and the back end loads its result from
// the queue head into the output register once that register is free. An item is
// accepted every cycle while the queue has room. The back end works through the
// candidate bytes and end mark of an entry one by one, so items giving one result
// each sustain one item per cycle while the receiver keeps up; a broken escape or an
// end item that releases held bytes gives the back end up to three slots, which the
// queue absorbs. Items that only start or extend an escape use no back-end time.
//
// Reset clears the escape state, the byte count, the overflow flag, the queue
// and the output valid flag, and sets capacity to 256. When the receiver stalls,
// the result holds in the output register, the queue fills, and in_ready drops
// once the queue is full.
module url_percent_decoder_unit import upd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  src_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic        status
);

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  entry_t q_head;

  // The front end never waits on the back end except through queue space.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd),
    .src_byte (src_byte),
    .push     (push),
    .entry    (push_entry)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .nonempty   (q_valid),
    .head       (q_head)
  );

  // The back end applies the capacity bound as bytes are released, in order.
  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status)
  );

endmodule

// ===== dv/tb_url_percent_decoder_unit.sv =====
// Self-checking testbench for the URL percent decoder unit.
`timescale 1ns / 1ps

module tb_url_percent_decoder_unit import upd_pkg::*;;

  // One decoded result item, in the order of the output ports.
  typedef struct packed {
    logic [7:0] data;
    logic       bv;
    logic       lst;
    logic       st;
  } result_t;

  // One row of the directed table. When chk is set, the typed result is what the
  // row must produce on its own; otherwise the row is checked against the predictor.
  typedef struct packed {
    logic       c;
    logic [7:0] b;
    logic       chk;
    result_t    want;
  } stim_row_t;

  localparam result_t R_NONE     = '0;
  localparam int      ITEM_GOAL  = 420;
  localparam int      CALM_AT    = 340;
  // Cycles to wait after the last result before touching the capacity register
  // or ending the run. Covers the queue and the back end with room to spare.
  localparam int      SETTLE     = 16;
  localparam int      DIR_SPLIT  = 25;
  localparam int      DIR_ROWS   = 28;

  // The first rows run at the reset capacity of 256; the rows from DIR_SPLIT on
  // run at a capacity of one, where every byte overflows.
  localparam stim_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    {CMD_BYTE, 8'h00,    1'b1, {8'h00, 1'b1, 1'b0, STATUS_OK}},
    {CMD_BYTE, 8'hFF,    1'b1, {8'hFF, 1'b1, 1'b0, STATUS_OK}},
    {CMD_BYTE, CH_PLUS,  1'b1, {CH_SPACE, 1'b1, 1'b0, STATUS_OK}},
    {CMD_BYTE, "~",      1'b1, {"~", 1'b1, 1'b0, STATUS_OK}},
    {CMD_BYTE, CH_PERCENT, 1'b0, R_NONE},
    {CMD_BYTE, "4",      1'b0, R_NONE},
    {CMD_BYTE, "1",      1'b0, R_NONE},
    {CMD_BYTE, CH_PERCENT, 1'b0, R_NONE},
    {CMD_BYTE, "f",      1'b0, R_NONE},
    {CMD_BYTE, "F",      1'b0, R_NONE},
    {CMD_BYTE, CH_PERCENT, 1'b0, R_NONE},
    {CMD_BYTE, "G",      1'b0, R_NONE},
    {CMD_BYTE, CH_PERCENT, 1'b0, R_NONE},
    {CMD_BYTE, "3",      1'b0, R_NONE},
    {CMD_BYTE, "z",      1'b0, R_NONE},
    {CMD_BYTE, CH_PERCENT, 1'b0, R_NONE},
    {CMD_BYTE, "2",      1'b0, R_NONE},
    {CMD_BYTE, CH_PERCENT, 1'b0, R_NONE},
    {CMD_BYTE, "a",      1'b0, R_NONE},
    {CMD_BYTE, "g",      1'b0, R_NONE},
    {CMD_BYTE, CH_PERCENT, 1'b0, R_NONE},
    {CMD_BYTE, CH_PERCENT, 1'b0, R_NONE},
    {CMD_BYTE, "0",      1'b0, R_NONE},
    {CMD_END,  8'hFF,    1'b0, R_NONE},
    {CMD_END,  8'h00,    1'b1, {8'h00, 1'b0, 1'b1, STATUS_OK}},
    {CMD_BYTE, "q",      1'b0, R_NONE},
    {CMD_BYTE, CH_PLUS,  1'b0, R_NONE},
    {CMD_END,  8'h5A,    1'b1, {8'h00, 1'b0, 1'b1, STATUS_OVERFLOW}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_BYTE;
  logic [7:0]  src_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic        status;

  url_percent_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .src_byte  (src_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .byte_valid(byte_valid),
    .last      (last),
    .status    (status)
  );

  // Decoded results still owed by the block, oldest first.
  result_t     owed[$];
  // Results produced by the predictor for the item just accepted.
  result_t     fresh[$];

  // Predictor state: escape progress, held digit, decoded length, overflow flag
  // and the capacity it was last programmed with.
  held_t       esc_state = HELD_NONE;
  logic [7:0]  esc_digit = '0;
  logic [15:0] dec_len = '0;
  bit          dec_overflow = 1'b0;
  logic [15:0] cap_now = CAPACITY_RESET;

  int n_fail = 0;
  int n_items = 0;
  int n_strings = 0;
  int n_matched = 0;
  int n_ovf_ends = 0;
  int n_settings = 0;

  // When calm is set, neither side starts a random pause any more.
  bit calm = 1'b0;
  bit tx_choppy = 1'b1;
  bit rx_choppy = 1'b1;
  int rx_hold = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Value of a hex digit character, or -1 for anything else.
  function automatic int nibble_of(input logic [7:0] ch);
    if (ch inside {[8'h30:8'h39]}) return int'(ch) - 'h30;
    if (ch inside {[8'h41:8'h46]}) return int'(ch) - 'h41 + 10;
    if (ch inside {[8'h61:8'h66]}) return int'(ch) - 'h61 + 10;
    return -1;
  endfunction

  // A decoded byte is kept only while the string plus its terminator still fits.
  // The first byte that does not fit sets the overflow flag, and from then on
  // nothing more is produced until the end of the string.
  task automatic emit_decoded(input logic [7:0] val);
    if (dec_overflow) return;
    if (int'(dec_len) + 1 >= int'(cap_now)) begin
      dec_overflow = 1'b1;
      return;
    end
    dec_len = dec_len + 16'd1;
    fresh.push_back({val, 1'b1, 1'b0, STATUS_OK});
  endtask

  // A broken or unfinished escape gives back what it held, literally.
  task automatic flush_pending();
    if (esc_state != HELD_NONE) emit_decoded(CH_PERCENT);
    if (esc_state == HELD_DIGIT) emit_decoded(esc_digit);
    esc_state = HELD_NONE;
    esc_digit = '0;
  endtask

  // A byte that does not continue an escape: a percent starts one, a plus
  // becomes a space, anything else, a zero byte included, passes as it is.
  task automatic take_plain(input logic [7:0] ch);
    if (ch == CH_PERCENT) begin
      esc_state = HELD_PERCENT;
      esc_digit = '0;
    end else if (ch == CH_PLUS) begin
      emit_decoded(CH_SPACE);
    end else begin
      emit_decoded(ch);
    end
  endtask

  // Works out every result that one accepted item gives, into fresh.
  task automatic decode_item(input logic c, input logic [7:0] ch);
    int lo;
    fresh.delete();
    if (c == CMD_END) begin
      flush_pending();
      fresh.push_back({8'h00, 1'b0, 1'b1, dec_overflow ? STATUS_OVERFLOW : STATUS_OK});
      dec_len = '0;
      dec_overflow = 1'b0;
      return;
    end
    lo = nibble_of(ch);
    case (esc_state)
      HELD_NONE: begin
        take_plain(ch);
      end
      HELD_PERCENT: begin
        if (lo >= 0) begin
          esc_state = HELD_DIGIT;
          esc_digit = ch;
        end else begin
          flush_pending();
          take_plain(ch);
        end
      end
      default: begin
        if (lo >= 0) begin
          esc_state = HELD_NONE;
          emit_decoded({4'(nibble_of(esc_digit)), lo[3:0]});
          esc_digit = '0;
        end else begin
          flush_pending();
          take_plain(ch);
        end
      end
    endcase
  endtask

  // Presents one item and holds it until the block takes it. The caller is at
  // a rising edge, so valid stays high across back-to-back items with a single
  // nonblocking assignment per edge.
  task automatic send_item(input logic c, input logic [7:0] ch, input bit chk,
                           input result_t want);
    in_valid <= 1'b1;
    cmd      <= c;
    src_byte <= ch;
    do @(posedge clk); while (!in_ready);
    decode_item(c, ch);
    if (chk) begin
      owed.push_back(want);
    end else begin
      foreach (fresh[i]) owed.push_back(fresh[i]);
    end
    foreach (fresh[i]) begin
      if (fresh[i].lst && fresh[i].st == STATUS_OVERFLOW) n_ovf_ends++;
    end
    if (c == CMD_END) n_strings++;
    n_items++;
    if (n_items >= CALM_AT) calm = 1'b1;
  endtask

  // Random sender gaps, only while the sender is choppy and the run is not yet calm.
  task automatic maybe_pause();
    if (!calm && tx_choppy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send(input logic c, input logic [7:0] ch);
    maybe_pause();
    send_item(c, ch, 1'b0, R_NONE);
  endtask

  // The sender stops until every owed result has come, then lets the block
  // settle. Capacity is only ever changed after this.
  task automatic drain();
    in_valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_now = val;
    n_settings++;
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'h30 + v[7:0];
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v[7:0] - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (nibble_of(ch) >= 0);
    return ch;
  endfunction

  // One string of random pieces: plain bytes, plus signs, good escapes, broken
  // escapes and raw noise, always closed by an end item.
  task automatic send_string(input int pieces);
    int kind;
    tx_choppy = $urandom_range(0, 2) != 0;
    for (int k = 0; k < pieces; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        send(CMD_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 50) begin
        send(CMD_BYTE, CH_PLUS);
      end else if (kind < 78) begin
        send(CMD_BYTE, CH_PERCENT);
        send(CMD_BYTE, hex_char());
        send(CMD_BYTE, hex_char());
      end else if (kind < 84) begin
        send(CMD_BYTE, CH_PERCENT);
        send(CMD_BYTE, non_hex_char());
      end else if (kind < 90) begin
        send(CMD_BYTE, CH_PERCENT);
        send(CMD_BYTE, hex_char());
        send(CMD_BYTE, non_hex_char());
      end else if (kind < 93) begin
        // An escape cut short by the end of the string.
        send(CMD_BYTE, CH_PERCENT);
        if ($urandom_range(0, 1)) send(CMD_BYTE, hex_char());
        k = pieces;
      end else begin
        send(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
    end
    send(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  // Receiver: ready most of the time, with random stalls while it is choppy and
  // the run is not yet calm; it flips between choppy and steady now and then.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else if (!calm && rx_choppy && $urandom_range(0, 6) == 0) begin
      rx_hold   <= $urandom_range(1, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if ($urandom_range(0, 59) == 0) rx_choppy <= !rx_choppy;
  end

  // Every accepted result is compared field by field with the oldest owed one.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (owed.size() == 0) begin
        $display("%0t: result with none owed, got byte %02h bv %0b last %0b status %0b",
                 $time, out_byte, byte_valid, last, status);
        n_fail++;
      end else begin
        want = owed.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_byte);
          n_fail++;
        end
        if (byte_valid !== want.bv) begin
          $display("%0t: byte_valid expected %0b, got %0b", $time, want.bv, byte_valid);
          n_fail++;
        end
        if (last !== want.lst) begin
          $display("%0t: last expected %0b, got %0b", $time, want.lst, last);
          n_fail++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0b, got %0b", $time, want.st, status);
          n_fail++;
        end
        n_matched++;
      end
    end
  end

  // Main sequence: reset, the directed table, then random strings over a
  // series of capacity settings, and finally the verdict.
  initial begin
    int ph;
    int pieces;
    logic [15:0] cap_pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. The first part relies on the reset capacity; before the
    // overflow rows the capacity drops to one.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_SPLIT) begin
        drain();
        set_capacity(16'd1);
      end
      maybe_pause();
      send_item(DIR_TABLE[i].c, DIR_TABLE[i].b, DIR_TABLE[i].chk, DIR_TABLE[i].want);
    end

    // Random part. The extremes of the capacity come first, then tight values
    // that overflow often, with the odd large or fully random one.
    ph = 0;
    while (n_items < ITEM_GOAL) begin
      case (ph)
        0: cap_pick = 16'd0;
        1: cap_pick = 16'hFFFF;
        2: cap_pick = 16'd2;
        3: cap_pick = 16'd3;
        4: cap_pick = CAPACITY_RESET;
        default: begin
          case ($urandom_range(0, 5))
            0: cap_pick = 16'($urandom_range(0, 16'hFFFF));
            1: cap_pick = CAPACITY_RESET;
            default: cap_pick = 16'($urandom_range(1, 24));
          endcase
        end
      endcase
      drain();
      set_capacity(cap_pick);
      repeat ($urandom_range(2, 6)) begin
        pieces = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 10);
        send_string(pieces);
      end
      ph++;
    end

    drain();
    $display("Ran %0d items in %0d strings over %0d capacity settings; %0d results compared.",
             n_items, n_strings, n_settings, n_matched);
    $display("%0d strings ended with the overflow status.", n_ovf_ends);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder_unit.sv
dv/tb_url_percent_decoder_unit.sv
